>>> hw/rtl/udpsdq_pkg.sv
// ----------------------------------------------------------------------------
// udpsdq_pkg
// Shared types, codes and constants of the UDP socket port demux queue.
// ----------------------------------------------------------------------------
package udpsdq_pkg;

  // default sizes of the socket table and of each receive queue
  localparam int DEF_SOCKET_COUNT = 8;
  localparam int DEF_QUEUE_DEPTH  = 8;

  // datagram length limit and width of a stored length
  localparam int LEN_W        = 11;
  localparam int MAX_DATAGRAM = 1500;

  // ephemeral port register and cursor after reset
  localparam logic [15:0] EPHEMERAL_RESET = 16'd49152;

  // action codes
  typedef enum logic [2:0] {
    ACT_ALLOC   = 3'd0,
    ACT_FREE    = 3'd1,
    ACT_BIND    = 3'd2,
    ACT_SEND    = 3'd3,
    ACT_DELIVER = 3'd4,
    ACT_RECV    = 3'd5
  } action_t;

  // status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_FREE     = 3'd1,
    ST_PORT_IN_USE = 3'd2,
    ST_NOT_DGRAM   = 3'd3,
    ST_NO_MATCH    = 3'd4,
    ST_QUEUE_FULL  = 3'd5,
    ST_EMPTY       = 3'd6
  } status_t;

  // command beat
  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  socket_index;
    logic [15:0] port;
    logic        is_datagram;
    logic [31:0] source_ip;
    logic [15:0] source_port;
    logic [15:0] length;
    logic [15:0] payload_handle;
  } cmd_beat_t;

  // response beat
  typedef struct packed {
    logic [2:0]       status;
    logic [2:0]       result_socket;
    logic [15:0]      local_port;
    logic [31:0]      out_source_ip;
    logic [15:0]      out_source_port;
    logic [15:0]      out_payload_handle;
    logic [LEN_W-1:0] copy_length;
  } rsp_beat_t;

  // one queued datagram descriptor
  typedef struct packed {
    logic [31:0]      source_ip;
    logic [15:0]      source_port;
    logic [LEN_W-1:0] length;
    logic [15:0]      handle;
  } entry_t;

  // decision of the socket table for one command
  typedef struct packed {
    status_t     status;
    logic [2:0]  rsock;
    logic [15:0] lport;
    logic        rd_ok;
    logic [15:0] req_len;
  } table_res_t;

endpackage

>>> hw/rtl/udp_socket_port_demux_queue_top.sv
// ----------------------------------------------------------------------------
// udp_socket_port_demux_queue_top
// UDP socket table with per-socket receive queues of datagram descriptors.
// ----------------------------------------------------------------------------
// One command beat is taken every cycle while the response side keeps up. The
// beat passes the input register (loaded at the accepting edge), where the
// socket table decides and updates in one pass, then the descriptor store
// read register, then the output register. The store read for a receive sets
// the middle stage. A stalled response freezes the whole pipe and stalls
// commands. The descriptor store has no reset and needs no clearing pass;
// commands are taken from the first cycle after reset. The ephemeral start
// register may be written only while no command is in flight.
module udp_socket_port_demux_queue_top #(
  parameter int SOCKET_COUNT = udpsdq_pkg::DEF_SOCKET_COUNT,
  parameter int QUEUE_DEPTH  = udpsdq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [15:0]           cfg_wdata,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  udpsdq_pkg::cmd_beat_t cmd,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output udpsdq_pkg::rsp_beat_t rsp
);
  import udpsdq_pkg::*;

  localparam int DEPTH  = SOCKET_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              advance;
  logic [15:0]       ephemeral_start;
  logic              s1_valid;
  cmd_beat_t         s1_beat;
  logic              s2_valid;
  table_res_t        s2_res;
  table_res_t        res;
  logic              st_we;
  logic              st_re;
  logic [ADDR_W-1:0] st_waddr;
  logic [ADDR_W-1:0] st_raddr;
  entry_t            st_wdata;
  entry_t            st_rdata;
  logic [15:0]       rd_len;

  // pipe moves unless a response beat is held
  assign advance   = !(rsp_valid && rsp_stall);
  assign cmd_stall = !advance;

  // ephemeral start register
  always_ff @(posedge clk) begin
    if (rst) begin
      ephemeral_start <= EPHEMERAL_RESET;
    end else if (cfg_wen) begin
      ephemeral_start <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_beat <= cmd;
    end
  end

  udpsdq_table #(
    .SOCKET_COUNT (SOCKET_COUNT),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .ADDR_W       (ADDR_W)
  ) u_table (
    .clk             (clk),
    .rst             (rst),
    .en              (s1_valid && advance),
    .beat            (s1_beat),
    .ephemeral_start (ephemeral_start),
    .res             (res),
    .st_we           (st_we),
    .st_waddr        (st_waddr),
    .st_wdata        (st_wdata),
    .st_re           (st_re),
    .st_raddr        (st_raddr)
  );

  udpsdq_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // decision stage, alongside the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_res <= res;
    end
  end

  // output register
  assign rd_len = 16'(st_rdata.length);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.status        <= s2_res.status;
      rsp.result_socket <= s2_res.rsock;
      rsp.local_port    <= s2_res.lport;
      if (s2_res.rd_ok) begin
        rsp.out_source_ip      <= st_rdata.source_ip;
        rsp.out_source_port    <= st_rdata.source_port;
        rsp.out_payload_handle <= st_rdata.handle;
        rsp.copy_length        <= (rd_len < s2_res.req_len) ? st_rdata.length
                                                            : LEN_W'(s2_res.req_len);
      end else begin
        rsp.out_source_ip      <= '0;
        rsp.out_source_port    <= '0;
        rsp.out_payload_handle <= '0;
        rsp.copy_length        <= '0;
      end
    end
  end

endmodule

>>> hw/rtl/udpsdq_store.sv
// ----------------------------------------------------------------------------
// udpsdq_store
// Descriptor memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module udpsdq_store #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  udpsdq_pkg::entry_t  wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  output udpsdq_pkg::entry_t  rdata
);
  import udpsdq_pkg::*;

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/udpsdq_table.sv
// ----------------------------------------------------------------------------
// udpsdq_table
// Socket slot table: decides each command in one pass, updates slot state and
// drives the descriptor store ports.
// ----------------------------------------------------------------------------
module udpsdq_table #(
  parameter int SOCKET_COUNT = 8,
  parameter int QUEUE_DEPTH  = 8,
  parameter int ADDR_W       = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  udpsdq_pkg::cmd_beat_t   beat,
  input  logic [15:0]             ephemeral_start,
  output udpsdq_pkg::table_res_t  res,
  output logic                    st_we,
  output logic [ADDR_W-1:0]       st_waddr,
  output udpsdq_pkg::entry_t      st_wdata,
  output logic                    st_re,
  output logic [ADDR_W-1:0]       st_raddr
);
  import udpsdq_pkg::*;

  localparam int SLOT_W = (SOCKET_COUNT > 1) ? $clog2(SOCKET_COUNT) : 1;
  localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = ((HEAD_W > CNT_W) ? HEAD_W : CNT_W) + 1;

  // slot state
  logic              in_use   [SOCKET_COUNT];
  logic              is_dgram [SOCKET_COUNT];
  logic [15:0]       bound    [SOCKET_COUNT];
  logic [HEAD_W-1:0] head     [SOCKET_COUNT];
  logic [CNT_W-1:0]  count    [SOCKET_COUNT];
  logic [15:0]       cursor;

  // decode
  logic              idx_ok;
  logic [SLOT_W-1:0] idx_s;
  logic              sel_dgram;
  logic [15:0]       sel_bound;
  logic [HEAD_W-1:0] sel_head;
  logic [CNT_W-1:0]  sel_count;
  logic [HEAD_W-1:0] head_next;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic              conflict;
  logic              match_found;
  logic [SLOT_W-1:0] match_slot;
  logic              match_full;
  logic [HEAD_W-1:0] wr_pos;
  logic [15:0]       cursor_next;
  logic [SUM_W-1:0]  wr_sum;
  logic [SUM_W-1:0]  head_inc;

  // addressed slot and lowest-slot searches
  always_comb begin
    idx_ok    = int'(beat.socket_index) < SOCKET_COUNT;
    idx_s     = SLOT_W'(beat.socket_index);
    sel_dgram = is_dgram[idx_s];
    sel_bound = bound[idx_s];
    sel_head  = head[idx_s];
    sel_count = count[idx_s];

    free_found  = 1'b0;
    free_slot   = '0;
    conflict    = 1'b0;
    match_found = 1'b0;
    match_slot  = '0;
    for (int i = SOCKET_COUNT - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
      if (in_use[i] && is_dgram[i] && bound[i] == beat.port) begin
        match_found = 1'b1;
        match_slot  = SLOT_W'(i);
      end
      if (SLOT_W'(i) != idx_s && in_use[i] && bound[i] == beat.port) begin
        conflict = 1'b1;
      end
    end

    // tail position of the matched queue, wrapped once
    match_full = count[match_slot] >= CNT_W'(QUEUE_DEPTH);
    wr_sum     = SUM_W'(head[match_slot]) + SUM_W'(count[match_slot]);
    if (wr_sum >= SUM_W'(QUEUE_DEPTH)) begin
      wr_sum = wr_sum - SUM_W'(QUEUE_DEPTH);
    end
    wr_pos = HEAD_W'(wr_sum);

    // head advance on dequeue
    head_inc = SUM_W'(sel_head) + SUM_W'(1);
    if (head_inc == SUM_W'(QUEUE_DEPTH)) begin
      head_inc = '0;
    end
    head_next = HEAD_W'(head_inc);

    // ephemeral cursor wraps to the start register
    cursor_next = cursor + 16'd1;
    if (cursor_next == 16'd0) begin
      cursor_next = ephemeral_start;
    end
  end

  // decision and store ports
  always_comb begin
    res         = '0;
    res.status  = ST_OK;
    res.req_len = beat.length;
    st_we       = 1'b0;
    st_re       = 1'b0;
    st_waddr    = ADDR_W'(match_slot) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wr_pos);
    st_raddr    = ADDR_W'(idx_s) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(sel_head);
    st_wdata.source_ip   = beat.source_ip;
    st_wdata.source_port = beat.source_port;
    st_wdata.handle      = beat.payload_handle;
    st_wdata.length      = (beat.length > 16'(MAX_DATAGRAM)) ? LEN_W'(MAX_DATAGRAM)
                                                               : LEN_W'(beat.length);
    case (beat.action)
      ACT_ALLOC: begin
        if (free_found) begin
          res.rsock = 3'(free_slot);
        end else begin
          res.status = ST_NO_FREE;
        end
      end
      ACT_BIND: begin
        if (!idx_ok) begin
          res.status = ST_NOT_DGRAM;
        end else if (conflict) begin
          res.status = ST_PORT_IN_USE;
        end
      end
      ACT_SEND: begin
        if (!idx_ok || !sel_dgram) begin
          res.status = ST_NOT_DGRAM;
        end else begin
          res.lport = (sel_bound == 16'd0) ? cursor : sel_bound;
        end
      end
      ACT_DELIVER: begin
        if (!match_found) begin
          res.status = ST_NO_MATCH;
        end else begin
          res.rsock = 3'(match_slot);
          if (match_full) begin
            res.status = ST_QUEUE_FULL;
          end else begin
            st_we = en;
          end
        end
      end
      ACT_RECV: begin
        if (!idx_ok || !sel_dgram) begin
          res.status = ST_NOT_DGRAM;
        end else if (sel_count == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.rd_ok = 1'b1;
          st_re     = en;
        end
      end
      default: begin
      end
    endcase
  end

  // slot state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SOCKET_COUNT; i++) begin
        in_use[i]   <= 1'b0;
        is_dgram[i] <= 1'b0;
        bound[i]    <= '0;
        head[i]     <= '0;
        count[i]    <= '0;
      end
      cursor <= EPHEMERAL_RESET;
    end else if (en) begin
      case (beat.action)
        ACT_ALLOC: begin
          if (free_found) begin
            in_use[free_slot]   <= 1'b1;
            is_dgram[free_slot] <= beat.is_datagram;
            bound[free_slot]    <= '0;
            head[free_slot]     <= '0;
            count[free_slot]    <= '0;
          end
        end
        ACT_FREE: begin
          // socket type is kept
          if (idx_ok) begin
            in_use[idx_s] <= 1'b0;
            bound[idx_s]  <= '0;
            head[idx_s]   <= '0;
            count[idx_s]  <= '0;
          end
        end
        ACT_BIND: begin
          if (idx_ok && !conflict) begin
            bound[idx_s] <= beat.port;
          end
        end
        ACT_SEND: begin
          if (idx_ok && sel_dgram && sel_bound == 16'd0) begin
            bound[idx_s] <= cursor;
            cursor       <= cursor_next;
          end
        end
        ACT_DELIVER: begin
          if (match_found && !match_full) begin
            count[match_slot] <= count[match_slot] + CNT_W'(1);
          end
        end
        ACT_RECV: begin
          if (idx_ok && sel_dgram && sel_count != '0) begin
            head[idx_s]  <= head_next;
            count[idx_s] <= sel_count - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/udpsdq_checker.sv
// ----------------------------------------------------------------------------
// udpsdq_checker
// Port-level checks of the UDP socket port demux queue, bound to the top.
// ----------------------------------------------------------------------------
module udpsdq_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  cmd_stall,
  input logic                  rsp_valid,
  input logic                  rsp_stall,
  input udpsdq_pkg::rsp_beat_t rsp
);
  import udpsdq_pkg::*;

  // no response beat straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // commands are only held back by a held response
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !cmd_stall)
    else $error("command stalled with no response pending");

  // a held response beat keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("held response beat changed");

  // failed actions carry no descriptor or port
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |->
      rsp.copy_length == '0 && rsp.out_payload_handle == '0 && rsp.local_port == '0)
    else $error("failed action carries data");

  // copy length never above the datagram limit
  a_copy_limit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp.copy_length) <= MAX_DATAGRAM)
    else $error("copy length above datagram limit");

endmodule

bind udp_socket_port_demux_queue_top udpsdq_checker u_checker (.*);
